// ----- rtl/core/nfci_pkg.sv -----
// Package for the NOR flash command interface: constants, codes and types.
package nfci_pkg;

  localparam int unsigned ChipBytesDefault   = 65536;
  localparam int unsigned SectorBytesDefault = 4096;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_ID0     = 3'd1,
    REG_ID1     = 3'd2,
    REG_ID2     = 3'd3,
    REG_ID3     = 3'd4,
    REG_UNLOCK1 = 3'd5,
    REG_UNLOCK2 = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_e;

  localparam logic [7:0] CmdNone    = 8'h00;
  localparam logic [7:0] CmdUnlock1 = 8'hAA;
  localparam logic [7:0] CmdUnlock2 = 8'h55;
  localparam logic [7:0] CmdCfi     = 8'h98;
  localparam logic [7:0] CmdReset   = 8'hF0;
  localparam logic [7:0] CmdBypass  = 8'h20;
  localparam logic [7:0] CmdErase   = 8'h80;
  localparam logic [7:0] CmdAutosel = 8'h90;
  localparam logic [7:0] CmdProgram = 8'hA0;
  localparam logic [7:0] CmdChipErs = 8'h10;
  localparam logic [7:0] CmdSecErs  = 8'h30;
  localparam logic [7:0] ErasedByte = 8'hFF;
  localparam logic [7:0] StatToggle = 8'h40;
  localparam logic [7:0] StatErase  = 8'h80;
  localparam logic [15:0] IdDisable = 16'h00FF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ARD,
    ST_AWAIT,
    ST_PROG,
    ST_PWAIT,
    ST_SWEEP,
    ST_OUT
  } state_e;

endpackage

// ----- rtl/core/nor_flash_command_interface_top.sv -----
// Top level of the NOR flash command interface with the byte-wide array memory.
//
// Requests enter on in_valid_i/in_ready_o with op_i, address_i, write_data_i,
// access_size_i and big_endian_i. Every request gives exactly one result on
// out_valid_o/out_ready_i carrying read_data_o (zero for writes and erase events).
// Registers are written on cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i.
// The array is one byte-wide synchronous RAM with a single port, so a multi-byte
// access walks its bytes one by one. A chip erase sweeps all CHIP_BYTES entries
// and a sector erase SECTOR_BYTES entries, one byte a cycle. After reset the
// block first sweeps the whole array to 0xFF and takes no request before that
// ends; registers may be written meanwhile.
// One request is in flight at a time. A result waits in the output register
// while the receiver stalls, and the next request is taken once it is gone.
module nor_flash_command_interface_top
  import nfci_pkg::*;
#(
  parameter int unsigned CHIP_BYTES   = ChipBytesDefault,
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  access_size_i,
  input  logic        big_endian_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(CHIP_BYTES);
  localparam int unsigned SW = $clog2(SECTOR_BYTES);

  logic [7:0] mem_q [CHIP_BYTES];
  logic [7:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  state_e state_q, state_d;

  logic [1:0]  width_q;
  logic [15:0] id0_q, id1_q, id2_q, id3_q, ua1_q, ua2_q;

  logic [2:0] wcyc_q, wcyc_d;
  logic [7:0] acmd_q, acmd_d;
  logic       byp_q, byp_d;
  logic [7:0] stat_q, stat_d;

  logic [1:0]  op_q;
  logic [15:0] addr_q;
  logic [31:0] wdata_q;
  logic [2:0]  nbytes_q;
  logic        be_q;

  logic [AW:0]   cnt_q, cnt_d;
  logic [AW:0]   end_q, end_d;
  logic [AW-1:0] base_q, base_d;
  logic [2:0]    k_q, k_d;
  logic [31:0]   res_q, res_d;

  logic [AW-1:0] off;
  logic [15:0]   idx_rd, idx_wr, off_rd, off_wr;
  logic [7:0]    cmd;
  logic [2:0]    lane;
  logic [4:0]    lsh;

  always_comb begin
    off    = addr_q[AW-1:0];
    off_rd = 16'(addr_q[7:0]);
    off_wr = 16'(addr_q[SW-1:0]);
    case (width_q)
      2'd1: begin
        idx_rd = off_rd >> 1;
        idx_wr = off_wr >> 1;
      end
      2'd2: begin
        idx_rd = off_rd >> 2;
        idx_wr = off_wr >> 2;
      end
      default: begin
        idx_rd = off_rd;
        idx_wr = off_wr;
      end
    endcase
    cmd  = wdata_q[7:0];
    lane = be_q ? (nbytes_q - 3'd1 - k_q) : k_q;
    lsh  = {lane[1:0], 3'b000};
  end

  // Register writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 2'd0;
      id0_q   <= 16'd0;
      id1_q   <= 16'd0;
      id2_q   <= IdDisable;
      id3_q   <= IdDisable;
      ua1_q   <= 16'h0555;
      ua2_q   <= 16'h02AA;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_WIDTH:   width_q <= cfg_data_i[1:0] == 2'd3 ? 2'd0 : cfg_data_i[1:0];
        REG_ID0:     id0_q   <= cfg_data_i;
        REG_ID1:     id1_q   <= cfg_data_i;
        REG_ID2:     id2_q   <= cfg_data_i;
        REG_ID3:     id3_q   <= cfg_data_i;
        REG_UNLOCK1: ua1_q   <= cfg_data_i;
        REG_UNLOCK2: ua2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign read_data_o = res_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_i;
      addr_q   <= address_i;
      wdata_q  <= write_data_i;
      nbytes_q <= (access_size_i == 2'd0) ? 3'd1 : (access_size_i == 2'd1) ? 3'd2 : 3'd4;
      be_q     <= big_endian_i;
    end
  end

  // Next state and datapath
  always_comb begin
    state_d = state_q;
    wcyc_d  = wcyc_q;
    acmd_d  = acmd_q;
    byp_d   = byp_q;
    stat_d  = stat_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    base_d  = base_q;
    k_d     = k_q;
    res_d   = res_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(CHIP_BYTES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
        k_d   = 3'd0;
        res_d = 32'd0;
      end
      ST_DECODE: begin
        state_d = ST_OUT;
        case (op_e'(op_q))
          OP_READ: begin
            case (acmd_q)
              CmdNone, CmdErase: state_d = ST_ARD;
              CmdAutosel: begin
                if (idx_rd == 16'd0) res_d = 32'(id0_q);
                else if (idx_rd == 16'd1) res_d = 32'(id1_q);
                else if (idx_rd == 16'd2) res_d = 32'd0;
                else if (idx_rd == 16'h0E && id2_q != IdDisable) res_d = 32'(id2_q);
                else if (idx_rd == 16'h0F && id3_q != IdDisable) res_d = 32'(id3_q);
                else state_d = ST_ARD;
              end
              CmdProgram, CmdChipErs, CmdSecErs: begin
                res_d  = 32'(stat_q);
                stat_d = stat_q ^ StatToggle;
              end
              CmdCfi: res_d = 32'd0;
              default: begin
                wcyc_d  = 3'd0;
                acmd_d  = CmdNone;
                state_d = ST_ARD;
              end
            endcase
          end
          OP_WRITE: begin
            if (acmd_q != CmdProgram && cmd == CmdReset) begin
              byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
            end else begin
              case (wcyc_q)
                3'd0, 3'd3: begin
                  if (wcyc_q == 3'd3 && acmd_q == CmdProgram) begin
                    stat_d  = wdata_q[7] ? 8'h7F : 8'hFF;
                    state_d = ST_PROG;
                    if (byp_q) begin
                      wcyc_d = 3'd2; acmd_d = CmdNone;
                    end else begin
                      byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                    end
                  end else if ((wcyc_q == 3'd0 || acmd_q == CmdErase ||
                                (acmd_q == CmdAutosel && !(byp_q && cmd == CmdNone)))
                               && idx_wr == 16'h55 && cmd == CmdCfi) begin
                    wcyc_d = 3'd7; acmd_d = CmdCfi;
                  end else if ((wcyc_q == 3'd0 || acmd_q == CmdErase)
                               && idx_wr == ua1_q && cmd == CmdUnlock1) begin
                    wcyc_d = wcyc_q + 3'd1;
                  end else begin
                    byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                  end
                end
                3'd1, 3'd4: begin
                  if (wcyc_q == 3'd4 && acmd_q == CmdProgram) begin
                  end else if ((wcyc_q == 3'd1 || acmd_q == CmdErase)
                               && idx_wr == ua2_q && cmd == CmdUnlock2) begin
                    wcyc_d = wcyc_q + 3'd1;
                  end else begin
                    byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                  end
                end
                3'd2: begin
                  if (!byp_q && idx_wr != ua1_q) begin
                    byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                  end else if (cmd == CmdBypass) begin
                    byp_d = 1'b1; wcyc_d = 3'd2; acmd_d = CmdNone;
                  end else if (cmd == CmdErase || cmd == CmdAutosel || cmd == CmdProgram) begin
                    acmd_d = cmd; wcyc_d = 3'd3;
                  end else begin
                    byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                  end
                end
                3'd5: begin
                  if (cmd == CmdChipErs && idx_wr == ua1_q) begin
                    stat_d = 8'd0; acmd_d = cmd; wcyc_d = 3'd6;
                    base_d = '0; cnt_d = '0; end_d = (AW+1)'(CHIP_BYTES);
                    state_d = ST_SWEEP;
                  end else if (cmd == CmdSecErs) begin
                    stat_d = 8'd0; acmd_d = cmd; wcyc_d = 3'd6;
                    base_d = off & ~AW'(SECTOR_BYTES - 1);
                    cnt_d = '0; end_d = (AW+1)'(SECTOR_BYTES);
                    state_d = ST_SWEEP;
                  end else begin
                    byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                  end
                end
                3'd6: begin
                  if (acmd_q != CmdChipErs && acmd_q != CmdSecErs) begin
                    byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                  end
                end
                default: begin
                  byp_d = 1'b0; wcyc_d = 3'd0; acmd_d = CmdNone;
                end
              endcase
            end
          end
          OP_ERASE: begin
            stat_d = stat_q ^ StatErase;
            wcyc_d = byp_q ? 3'd2 : 3'd0;
            acmd_d = CmdNone;
          end
          default: ;
        endcase
      end
      ST_ARD: state_d = ST_AWAIT;
      ST_AWAIT: begin
        res_d = res_q | (32'(rdata_q) << lsh);
        k_d   = k_q + 3'd1;
        state_d = (k_q + 3'd1 == nbytes_q) ? ST_OUT : ST_ARD;
      end
      ST_PROG: state_d = ST_PWAIT;
      ST_PWAIT: begin
        k_d   = k_q + 3'd1;
        state_d = (k_q + 3'd1 == nbytes_q) ? ST_OUT : ST_PROG;
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == end_q) state_d = ST_OUT;
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = off + AW'(k_q);
    mem_wdata = rdata_q & wdata_q[lsh +: 8];
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_q[AW-1:0];
        mem_wdata = ErasedByte;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = base_q + cnt_q[AW-1:0];
        mem_wdata = ErasedByte;
      end
      ST_PWAIT: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wcyc_q  <= 3'd0;
      acmd_q  <= CmdNone;
      byp_q   <= 1'b0;
      stat_q  <= 8'd0;
      cnt_q   <= '0;
      k_q     <= 3'd0;
    end else begin
      state_q <= state_d;
      wcyc_q  <= wcyc_d;
      acmd_q  <= acmd_d;
      byp_q   <= byp_d;
      stat_q  <= stat_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q  <= end_d;
    base_q <= base_d;
    res_q  <= res_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken while result pending");
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AWAIT || state_q == ST_PWAIT) |-> k_q < nbytes_q)
    else $error("byte index past access size");
  a_bypass_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && byp_q |-> wcyc_q != 3'd0 && wcyc_q != 3'd1)
    else $error("bypass mode with unlock cycle pending");

endmodule
